@@ design/isf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isf_pkg: shared types for the input session failsafe
// Event codes, session modes, result status codes and stream field widths.
// ----------------------------------------------------------------------------
package isf_pkg;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_START      = 3'd1,
        OP_FRAME      = 3'd2,
        OP_DISCONNECT = 3'd3,
        OP_STOP       = 3'd4,
        OP_SEND       = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        MODE_CREATED      = 3'd0,
        MODE_RUNNING      = 3'd1,
        MODE_STOPPED      = 3'd2,
        MODE_DISCONNECTED = 3'd3,
        MODE_FAULTED      = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_STALE   = 3'd2,
        ST_BACKEND = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    localparam int unsigned IN_DATA_BITS  = 200;
    localparam int unsigned OUT_DATA_BITS = 264;

    localparam logic REG_TIMEOUT_TICKS = 1'b0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

endpackage

@@ design/input_session_failsafe_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_session_failsafe_top: session failsafe with sequence check
// Tracks the session mode, filters incoming frames and outgoing sends by
// sequence number, and drives a neutral payload on timeouts, disconnects, stops and most faults.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Contents
//  -------   ---------  -------------------------  ------------------------------
//  s_*       in         s_tvalid / s_tready        one event item
//  m_*       out        m_tvalid / m_tready        one result item per event
//  APB       in/out     psel & penable & pwrite    timeout_ticks at address 0
//
// An event item is registered in the input register. When the pipe advances,
// the state update and the result register load happen together, and the
// result item is then held in the result register until m_tready takes it.
// A new item can be accepted in every cycle while m_tready does not hold the pipe;
// the sustained rate is then one item per clock, set by the single state update step.
// Reset clears the session state and both stage valid flags; timeout_ticks
// returns to 100. When the result register is full and m_tready is low, the
// input register holds and s_tready drops only once it is full as well.
//
module input_session_failsafe_top #(
    parameter int unsigned PAYLOAD_BITS = 64,
    parameter int unsigned COUNT_BITS   = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Event stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata, from bit 0: item_sequence[63:0], item_timestamp[127:64],
    // item_payload[191:128], controller_ok[192], transport_ok[193], zero fill.
    input  logic [isf_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // s_tuser: opcode[2:0].
    input  logic [2:0]                         s_tuser,
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata, from bit 0: status[2:0], session_mode[5:3],
    // drive_payload[69:6], neutralized_now[70], newest_sequence[134:71],
    // accepted_total[166:135], neutral_total[198:167],
    // newest_timestamp[262:199], zero fill.
    output logic [isf_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [15:0] timeout_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == isf_pkg::REG_TIMEOUT_TICKS);
    assign prdata    = (paddr[2] == isf_pkg::REG_TIMEOUT_TICKS) ?
                       {16'd0, timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= isf_pkg::TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            timeout_reg <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Input register and pipeline control. The whole pipe advances when the
    // result register is empty or being drained.
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [63:0] seq_reg;
    logic [63:0] stamp_reg;
    logic [63:0] pay_in_reg;
    logic        ctl_ok_reg;
    logic        tr_ok_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        process;
    logic        s_take;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;
    assign process  = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            op_reg     <= s_tuser;
            seq_reg    <= s_tdata[63:0];
            stamp_reg  <= s_tdata[127:64];
            pay_in_reg <= s_tdata[191:128];
            ctl_ok_reg <= s_tdata[192];
            tr_ok_reg  <= s_tdata[193];
        end
    end

    // ------------------------------------------------------------------
    // Session state.
    // ------------------------------------------------------------------
    isf_pkg::mode_t          mode_reg, mode_next;
    logic                    sent_any_reg, sent_any_next;
    logic [63:0]             high_sent_reg, high_sent_next;
    logic [63:0]             last_seq_reg, last_seq_next;
    logic [COUNT_BITS-1:0]   acc_cnt_reg, acc_cnt_next;
    logic [COUNT_BITS-1:0]   neut_cnt_reg, neut_cnt_next;
    logic [63:0]             last_stamp_reg, last_stamp_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic                    armed_reg, armed_next;
    logic [15:0]             idle_reg, idle_next;
    isf_pkg::status_t        status;
    logic                    neut;

    logic [15:0]             idle_inc;
    logic                    frame_newer;
    logic                    send_newer;

    assign idle_inc    = (idle_reg < isf_pkg::IDLE_MAX) ? idle_reg + 16'd1 : idle_reg;
    assign frame_newer = (acc_cnt_reg == '0) || (seq_reg > last_seq_reg);
    assign send_newer  = !sent_any_reg || (seq_reg > high_sent_reg);

    always_comb
    begin
        mode_next       = mode_reg;
        sent_any_next   = sent_any_reg;
        high_sent_next  = high_sent_reg;
        last_seq_next   = last_seq_reg;
        acc_cnt_next    = acc_cnt_reg;
        last_stamp_next = last_stamp_reg;
        payload_next    = payload_reg;
        armed_next      = armed_reg;
        idle_next       = idle_reg;
        status          = isf_pkg::ST_OK;
        neut            = 1'b0;

        case (op_reg)
            isf_pkg::OP_TICK:
            begin
                if (mode_reg == isf_pkg::MODE_RUNNING && armed_reg)
                begin
                    idle_next = idle_inc;
                    if (idle_inc >= timeout_reg)
                    begin
                        neut = 1'b1;
                    end
                end
            end
            isf_pkg::OP_START:
            begin
                if (mode_reg != isf_pkg::MODE_CREATED)
                begin
                    status = isf_pkg::ST_INVALID;
                end
                else if (!ctl_ok_reg)
                begin
                    mode_next = isf_pkg::MODE_FAULTED;
                    status    = isf_pkg::ST_BACKEND;
                end
                else if (!tr_ok_reg)
                begin
                    mode_next = isf_pkg::MODE_FAULTED;
                    neut      = 1'b1;
                    status    = isf_pkg::ST_BACKEND;
                end
                else
                begin
                    mode_next = isf_pkg::MODE_RUNNING;
                end
            end
            isf_pkg::OP_FRAME:
            begin
                if (mode_reg != isf_pkg::MODE_RUNNING || !frame_newer)
                begin
                    status = isf_pkg::ST_IGNORED;
                end
                else if (!ctl_ok_reg)
                begin
                    mode_next = isf_pkg::MODE_FAULTED;
                    neut      = 1'b1;
                    status    = isf_pkg::ST_BACKEND;
                end
                else
                begin
                    payload_next    = pay_in_reg[PAYLOAD_BITS-1:0];
                    last_seq_next   = seq_reg;
                    acc_cnt_next    = (acc_cnt_reg == COUNT_MAX) ?
                                      acc_cnt_reg : acc_cnt_reg + COUNT_BITS'(1);
                    last_stamp_next = stamp_reg;
                    armed_next      = 1'b1;
                    idle_next       = 16'd0;
                end
            end
            isf_pkg::OP_DISCONNECT:
            begin
                if (mode_reg != isf_pkg::MODE_RUNNING)
                begin
                    status = isf_pkg::ST_INVALID;
                end
                else
                begin
                    mode_next = isf_pkg::MODE_DISCONNECTED;
                    neut      = 1'b1;
                end
            end
            isf_pkg::OP_STOP:
            begin
                if (mode_reg == isf_pkg::MODE_CREATED)
                begin
                    mode_next = isf_pkg::MODE_STOPPED;
                end
                else if (mode_reg == isf_pkg::MODE_RUNNING)
                begin
                    mode_next = isf_pkg::MODE_STOPPED;
                    neut      = 1'b1;
                end
            end
            isf_pkg::OP_SEND:
            begin
                if (mode_reg != isf_pkg::MODE_RUNNING)
                begin
                    status = isf_pkg::ST_INVALID;
                end
                else if (!send_newer)
                begin
                    status = isf_pkg::ST_STALE;
                end
                else
                begin
                    sent_any_next  = 1'b1;
                    high_sent_next = seq_reg;
                    if (!tr_ok_reg)
                    begin
                        mode_next = isf_pkg::MODE_DISCONNECTED;
                        neut      = 1'b1;
                        status    = isf_pkg::ST_BACKEND;
                    end
                end
            end
            default:
            begin
                status = isf_pkg::ST_IGNORED;
            end
        endcase

        // A neutralization drops the payload and disarms the watchdog.
        if (neut)
        begin
            payload_next = '0;
            armed_next   = 1'b0;
        end
        neut_cnt_next = (neut && neut_cnt_reg != COUNT_MAX) ?
                        neut_cnt_reg + COUNT_BITS'(1) : neut_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= isf_pkg::MODE_CREATED;
            sent_any_reg   <= 1'b0;
            high_sent_reg  <= '0;
            last_seq_reg   <= '0;
            acc_cnt_reg    <= '0;
            neut_cnt_reg   <= '0;
            last_stamp_reg <= '0;
            payload_reg    <= '0;
            armed_reg      <= 1'b0;
            idle_reg       <= '0;
        end
        else if (process)
        begin
            mode_reg       <= mode_next;
            sent_any_reg   <= sent_any_next;
            high_sent_reg  <= high_sent_next;
            last_seq_reg   <= last_seq_next;
            acc_cnt_reg    <= acc_cnt_next;
            neut_cnt_reg   <= neut_cnt_next;
            last_stamp_reg <= last_stamp_next;
            payload_reg    <= payload_next;
            armed_reg      <= armed_next;
            idle_reg       <= idle_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register. Counters are reported in their low 32 bits and the
    // payload is zero extended to the full field width.
    // ------------------------------------------------------------------
    logic [63:0]                      acc_wide;
    logic [63:0]                      neut_wide;
    logic [isf_pkg::OUT_DATA_BITS-1:0] result_next;
    logic [isf_pkg::OUT_DATA_BITS-1:0] result_reg;

    assign acc_wide  = 64'(acc_cnt_next);
    assign neut_wide = 64'(neut_cnt_next);

    assign result_next = {1'b0,
                          last_stamp_next,
                          neut_wide[31:0],
                          acc_wide[31:0],
                          last_seq_next,
                          neut,
                          64'(payload_next),
                          3'(mode_next),
                          3'(status)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A result that reports a neutralization always shows a zero payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg[70]) |-> (result_reg[69:6] == 64'd0))
        else $error("neutralized result carries a nonzero payload");

    // The neutralization count never moves backward.
    assert property (@(posedge clk) disable iff (!rst_n)
        process |=> (neut_cnt_reg >= $past(neut_cnt_reg)))
        else $error("neutralization count decreased");

    // No frame is counted unless the session was running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && mode_reg != isf_pkg::MODE_RUNNING) |=>
        (acc_cnt_reg == $past(acc_cnt_reg)))
        else $error("frame counted outside the running mode");

    // The event side stalls only when both stages are full and blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipe");

endmodule
